// ===== sv/gmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gmcd_pkg
// Shared constants for the grid same-color cycle detector.
// ----------------------------------------------------------------------------
package gmcd_pkg;
    localparam int CFG_IDX_W  = 2;  // register index width
    localparam int CFG_DATA_W = 7;  // register data width
    localparam int COLOR_W    = 8;  // color byte width

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
endpackage

// ===== sv/grid_monochrome_cycle_detect_core.sv =====
// ----------------------------------------------------------------------------
// grid_monochrome_cycle_detect_core
// Stores a color grid cell by cell, then runs a union-find over same-color
// neighbor edges held in a parent RAM and reports whether any cycle exists.
// ----------------------------------------------------------------------------
// Load: one cell per cycle, s_tready high whenever the block is loading.
// Search: every parent RAM entry is first set to point to itself, then each
//   cell is compared with its right and lower neighbors; a same-color pair
//   finds both roots in the parent RAM and links them, or flags a cycle.
// The result register is written once any earlier result is taken; loading resumes with it.
// Synchronous active-low reset: back to loading, no result; RAMs not cleared.
// ----------------------------------------------------------------------------
module grid_monochrome_cycle_detect_core
    import gmcd_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // cell stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] cell_colour
    input  logic                  i_s_tlast,   // last_cell
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [0] has_cycle, [7:1] zero
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int TW    = RCW + CCW;  // holds rows*cols and indexes up to it

    typedef enum logic [3:0] {
        ST_LOAD, ST_INIT, ST_CUR, ST_C0, ST_NREQ, ST_CMP,
        ST_FRD, ST_FCHK, ST_NEXT, ST_DONE
    } t_state;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_rows_cfg, r_cols_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= CFG_DATA_W'(1);
            r_cols_cfg <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW_COUNT: r_rows_cfg <= i_cfg_data;
                REG_COL_COUNT: r_cols_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // saturated dimensions
    logic [RCW-1:0] eff_rows;
    logic [CCW-1:0] eff_cols;
    logic [TW-1:0]  total;

    always_comb begin
        if (r_rows_cfg == '0)                     eff_rows = RCW'(1);
        else if (32'(r_rows_cfg) > MAX_ROWS)      eff_rows = RCW'(MAX_ROWS);
        else                                      eff_rows = RCW'(r_rows_cfg);
        if (r_cols_cfg == '0)                     eff_cols = CCW'(1);
        else if (32'(r_cols_cfg) > MAX_COLS)      eff_cols = CCW'(MAX_COLS);
        else                                      eff_cols = CCW'(r_cols_cfg);
        total = TW'(eff_rows) * TW'(eff_cols);
    end

    // state
    t_state         r_state;
    logic [TW-1:0]  r_load_idx;
    logic [TW-1:0]  r_here;
    logic [RCW-1:0] r_row;
    logic [CCW-1:0] r_col;
    logic           r_dir;      // 0: right neighbor, 1: lower neighbor
    logic           r_phase;    // 0: finding root of a, 1: root of b
    logic [COLOR_W-1:0] r_c0;
    logic [AW-1:0]  r_b, r_x, r_ra;
    logic           r_found;

    // RAM ports
    logic               col_we;
    logic [AW-1:0]      col_waddr, col_raddr;
    logic [COLOR_W-1:0] col_rdata;
    logic               lnk_we;
    logic [AW-1:0]      lnk_waddr, lnk_wdata, lnk_raddr;
    logic [AW-1:0]      lnk_rdata;

    gmcd_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_color_ram (
        .i_clk  (i_clk),
        .i_we   (col_we),
        .i_waddr(col_waddr),
        .i_wdata(i_s_tdata),
        .i_raddr(col_raddr),
        .o_rdata(col_rdata)
    );

    gmcd_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (lnk_we),
        .i_waddr(lnk_waddr),
        .i_wdata(lnk_wdata),
        .i_raddr(lnk_raddr),
        .o_rdata(lnk_rdata)
    );

    logic          s_acc;
    logic          nb_exists;
    logic [TW-1:0] nb_idx;
    logic          last_here;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_LOAD);
    assign last_here  = (r_here == total - TW'(1));

    always_comb begin
        if (!r_dir) begin
            nb_exists = (TW'(r_col) + TW'(1)) < TW'(eff_cols);
            nb_idx    = r_here + TW'(1);
        end else begin
            nb_exists = (TW'(r_row) + TW'(1)) < TW'(eff_rows);
            nb_idx    = r_here + TW'(eff_cols);
        end
    end

    // memory addressing
    always_comb begin
        col_we    = (r_state == ST_LOAD) && s_acc && (r_load_idx < total);
        col_waddr = AW'(r_load_idx);
        col_raddr = (r_state == ST_NREQ) ? AW'(nb_idx) : AW'(r_here);
        lnk_we    = 1'b0;
        lnk_waddr = AW'(r_here);
        lnk_wdata = AW'(r_here);
        lnk_raddr = r_x;
        if (r_state == ST_INIT) begin
            lnk_we = 1'b1;
        end else if (r_state == ST_FCHK && lnk_rdata == r_x && r_phase
                     && r_ra != r_x) begin
            lnk_we    = 1'b1;   // link root of a under root of b
            lnk_waddr = r_ra;
            lnk_wdata = r_x;
        end
    end

    // sequencer; after the right edge go to the lower one, after the lower
    // edge step to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_idx <= '0;
            r_found    <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready && r_state != ST_DONE) o_m_tvalid <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (r_load_idx < total) r_load_idx <= r_load_idx + TW'(1);
                        if (i_s_tlast) begin
                            r_state <= ST_INIT;
                            r_here  <= '0;
                            r_found <= 1'b0;
                        end
                    end
                end
                ST_INIT: begin
                    if (last_here) begin
                        r_here  <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= ST_CUR;
                    end else begin
                        r_here <= r_here + TW'(1);
                    end
                end
                ST_CUR: r_state <= ST_C0;
                ST_C0: begin
                    r_c0    <= col_rdata;
                    r_dir   <= 1'b0;
                    r_state <= ST_NREQ;
                end
                ST_NREQ: begin
                    if (nb_exists) begin
                        r_b     <= AW'(nb_idx);
                        r_state <= ST_CMP;
                    end else if (!r_dir) begin
                        r_dir <= 1'b1;
                    end else begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_CMP: begin
                    if (col_rdata == r_c0) begin
                        r_x     <= AW'(r_here);
                        r_phase <= 1'b0;
                        r_state <= ST_FRD;
                    end else begin
                        r_dir   <= 1'b1;
                        r_state <= r_dir ? ST_NEXT : ST_NREQ;
                    end
                end
                ST_FRD: r_state <= ST_FCHK;
                ST_FCHK: begin
                    if (lnk_rdata != r_x) begin
                        r_x     <= lnk_rdata;
                        r_state <= ST_FRD;
                    end else if (!r_phase) begin
                        r_ra    <= r_x;
                        r_x     <= r_b;
                        r_phase <= 1'b1;
                        r_state <= ST_FRD;
                    end else if (r_ra == r_x) begin
                        r_found <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_dir   <= 1'b1;
                        r_state <= r_dir ? ST_NEXT : ST_NREQ;
                    end
                end
                ST_NEXT: begin
                    if (last_here) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_here <= r_here + TW'(1);
                        if (TW'(r_col) + TW'(1) == TW'(eff_cols)) begin
                            r_col <= '0;
                            r_row <= r_row + RCW'(1);
                        end else begin
                            r_col <= r_col + CCW'(1);
                        end
                        r_state <= ST_CUR;
                    end
                end
                ST_DONE: begin
                    if (!o_m_tvalid || i_m_tready) begin
                        o_m_tvalid <= 1'b1;
                        o_m_tdata  <= {7'd0, r_found};
                        r_load_idx <= '0;
                        r_state    <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end
endmodule

// ===== sv/gmcd_ram.sv =====
// ----------------------------------------------------------------------------
// gmcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gmcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/gmcd_checker.sv =====
// ----------------------------------------------------------------------------
// gmcd_checker
// Port-level checks on the cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
module gmcd_props
    import gmcd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [7:0]            i_s_tdata,
    input logic                  i_s_tlast,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [7:0]            o_m_tdata,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // loading stops only after the last cell of a grid
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(i_s_tvalid && i_s_tlast))
        else $error("load stopped without a last cell");

    // a new result appears together with the return to loading
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $rose(o_s_tready))
        else $error("result without end of search");

    // pad bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:1] == 7'd0)
        else $error("nonzero pad bits");
endmodule

bind grid_monochrome_cycle_detect_core gmcd_props u_gmcd_props (.*);
